### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define EPTV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define EPTV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/eptv_pkg.sv
`timescale 1ns / 1ps

package eptv_pkg;

  localparam int PIXEL_BITS  = 16;
  localparam int ACC_BITS    = 48;
  localparam int OUT_BITS    = 48;
  localparam int HALF_BITS   = ACC_BITS / 2;
  localparam int INV_BITS    = 17;
  localparam int PROD_BITS   = HALF_BITS + INV_BITS;
  localparam int HEIGHT_BITS = 11;
  localparam int ROW_BITS    = 10;
  localparam int PLANE_BITS  = 16;
  localparam int CFG_BITS    = 17;
  localparam int INDEX_BITS  = 2;
  localparam int FRAC_SHIFT  = 8;

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT = 11'd1024;
  localparam logic [INV_BITS-1:0]    INV_ONE      = 17'h10000;
  localparam logic [ACC_BITS-1:0]    ACC_MAX      = {ACC_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0]    OUT_MAX      = {OUT_BITS{1'b1}};

  localparam logic [INDEX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_PLANES = 2'd2;
  localparam logic [INDEX_BITS-1:0] REG_INV    = 2'd3;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] predicted;
    logic signed [PIXEL_BITS-1:0] target;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] loss;
    logic                saturated;
  } result_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height;
    logic [PLANE_BITS-1:0]  planes;
  } limits_t;

  typedef struct packed {
    logic                done;
    logic [ACC_BITS-1:0] square_sum;
    logic [ACC_BITS-1:0] variation_sum;
    logic                overflow;
  } sums_t;

endpackage

### design/euclidean_plus_tv_loss.sv
`timescale 1ns / 1ps
// Throughput: one pixel word per cycle within a batch, one row store access each way a cycle.
// Result path: the last pixel word goes through the input register, the sum update, done and the
// scale states LOW, HIGH and ROUND. Batch end: input stalls while the split 24x17 multiply and
// rounding run, longer while the previous result word is still held off.
// Reset: synchronous on rst; clears positions, sums, flag, output valid and loads register
// defaults (width 1, height 1, one plane, reciprocal 1.0). The row store is not cleared.

`include "assert_macros.svh"

module euclidean_plus_tv_loss #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [eptv_pkg::INDEX_BITS-1:0]     cfg_index,
  input  logic [eptv_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  eptv_pkg::pixel_t                    pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output eptv_pkg::result_t                   result
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [eptv_pkg::HEIGHT_BITS-1:0] image_width;
  logic [eptv_pkg::HEIGHT_BITS-1:0] image_height;
  logic [eptv_pkg::PLANE_BITS-1:0]  plane_count;
  logic [eptv_pkg::INV_BITS-1:0]    inv_sample_count;

  logic [COL_BITS:0]             width_eff;
  eptv_pkg::limits_t             limits;
  logic [eptv_pkg::INV_BITS-1:0] inv_eff;
  logic                          accept;
  logic                          accum_busy;
  logic                          scale_busy;
  eptv_pkg::sums_t               sums;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 11'd1;
      image_height     <= 11'd1;
      plane_count      <= 16'd1;
      inv_sample_count <= eptv_pkg::INV_ONE;
    end else if (cfg_write) begin
      case (cfg_index)
        eptv_pkg::REG_WIDTH:  image_width      <= cfg_data[eptv_pkg::HEIGHT_BITS-1:0];
        eptv_pkg::REG_HEIGHT: image_height     <= cfg_data[eptv_pkg::HEIGHT_BITS-1:0];
        eptv_pkg::REG_PLANES: plane_count      <= cfg_data[eptv_pkg::PLANE_BITS-1:0];
        eptv_pkg::REG_INV:    inv_sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      width_eff = (COL_BITS+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = (COL_BITS+1)'(MAX_WIDTH);
    end else begin
      width_eff = (COL_BITS+1)'(image_width);
    end
    if (image_height == '0) begin
      limits.height = 11'd1;
    end else if (image_height > eptv_pkg::HEIGHT_LIMIT) begin
      limits.height = eptv_pkg::HEIGHT_LIMIT;
    end else begin
      limits.height = image_height;
    end
    limits.planes = (plane_count == '0) ? 16'd1 : plane_count;
    inv_eff = (inv_sample_count > eptv_pkg::INV_ONE) ? eptv_pkg::INV_ONE : inv_sample_count;
  end

  assign pixel_stall = accum_busy || scale_busy;
  assign accept      = pixel_valid && !pixel_stall;

  eptv_accum #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (pixel),
    .width_eff (width_eff),
    .limits    (limits),
    .busy      (accum_busy),
    .sums      (sums)
  );

  eptv_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .sums         (sums),
    .inv          (inv_eff),
    .busy         (scale_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `EPTV_ASSERT_NEXT(a_done_starts_scale, sums.done, scale_busy)
  `EPTV_ASSERT_NEXT(a_sums_cleared, sums.done, (sums.square_sum == '0) && (sums.variation_sum == '0) && !sums.overflow)
  `EPTV_ASSERT_IMP(a_result_from_scale, $rose(result_valid), $past(scale_busy))

endmodule

### design/eptv_ram.sv
`timescale 1ns / 1ps

module eptv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/eptv_accum.sv
`timescale 1ns / 1ps

module eptv_accum #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  eptv_pkg::pixel_t           pixel,
  input  logic [$clog2(MAX_WIDTH):0] width_eff,
  input  eptv_pkg::limits_t          limits,
  output logic                       busy,
  output eptv_pkg::sums_t            sums
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int PB = eptv_pkg::PIXEL_BITS;
  localparam int AB = eptv_pkg::ACC_BITS;
  localparam int TERM_BITS = PB + 1 + eptv_pkg::FRAC_SHIFT;

  function automatic logic [PB:0] abs_diff(input logic [PB-1:0] a, input logic [PB-1:0] b);
    logic [PB:0] diff;
    diff = {a[PB-1], a} - {b[PB-1], b};
    abs_diff = diff[PB] ? (~diff + 1'b1) : diff;
  endfunction

  logic [COL_BITS-1:0]             column_pos;
  logic [eptv_pkg::ROW_BITS-1:0]   row_pos;
  logic [eptv_pkg::PLANE_BITS-1:0] plane_pos;
  logic                            col_end;
  logic                            row_end;
  logic                            plane_end;

  logic                s1_valid;
  logic                s1_last;
  logic                s1_above_ok;
  logic                s1_left_ok;
  logic                s1_fwd;
  logic [PB-1:0]       s1_pred;
  logic [PB-1:0]       s1_target;
  logic [COL_BITS-1:0] s1_col;

  logic [PB-1:0] left_pixel;
  logic [PB-1:0] line_word;
  logic [PB-1:0] above;
  logic [AB-1:0] square_sum;
  logic [AB-1:0] variation_sum;
  logic          overflow;
  logic          done;

  logic [PB:0]          err_mag;
  logic [2*PB+1:0]      sq;
  logic [PB:0]          vert_mag;
  logic [PB:0]          horz_mag;
  logic [TERM_BITS-1:0] vert_term;
  logic [TERM_BITS-1:0] horz_term;
  logic [AB:0]          square_total;
  logic [AB:0]          var_total;

  eptv_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (s1_pred),
    .rd_en   (accept),
    .rd_addr (column_pos),
    .rd_data (line_word)
  );

  assign col_end   = ({1'b0, column_pos} + 1'b1) >= width_eff;
  assign row_end   = ({1'b0, row_pos} + 1'b1) >= limits.height;
  assign plane_end = ({1'b0, plane_pos} + 1'b1) >= {1'b0, limits.planes};

  always_comb begin
    above        = s1_fwd ? left_pixel : line_word;
    err_mag      = abs_diff(s1_pred, s1_target);
    sq           = err_mag * err_mag;
    vert_mag     = abs_diff(s1_pred, above);
    horz_mag     = abs_diff(s1_pred, left_pixel);
    vert_term    = s1_above_ok ? {vert_mag, 8'b0} : '0;
    horz_term    = s1_left_ok ? {horz_mag, 8'b0} : '0;
    square_total = {1'b0, square_sum} + (AB+1)'(sq);
    var_total    = {1'b0, variation_sum} + (AB+1)'(vert_term) + (AB+1)'(horz_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos    <= '0;
      row_pos       <= '0;
      plane_pos     <= '0;
      s1_valid      <= 1'b0;
      done          <= 1'b0;
      square_sum    <= '0;
      variation_sum <= '0;
      overflow      <= 1'b0;
      left_pixel    <= '0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid && s1_last;
      if (accept) begin
        if (!col_end) begin
          column_pos <= column_pos + 1'b1;
        end else begin
          column_pos <= '0;
          if (!row_end) begin
            row_pos <= row_pos + 1'b1;
          end else begin
            row_pos <= '0;
            if (!plane_end) begin
              plane_pos <= plane_pos + 1'b1;
            end else begin
              plane_pos <= '0;
            end
          end
        end
      end
      if (done) begin
        square_sum    <= '0;
        variation_sum <= '0;
        overflow      <= 1'b0;
        left_pixel    <= '0;
      end else if (s1_valid) begin
        square_sum    <= square_total[AB] ? eptv_pkg::ACC_MAX : square_total[AB-1:0];
        variation_sum <= var_total[AB] ? eptv_pkg::ACC_MAX : var_total[AB-1:0];
        overflow      <= overflow | square_total[AB] | var_total[AB];
        left_pixel    <= s1_pred;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pred     <= pixel.predicted;
      s1_target   <= pixel.target;
      s1_col      <= column_pos;
      s1_above_ok <= row_pos != '0;
      s1_left_ok  <= column_pos != '0;
      s1_last     <= col_end && row_end && plane_end;
      s1_fwd      <= s1_valid && (s1_col == column_pos);
    end
  end

  assign busy = (s1_valid && s1_last) || done;

  assign sums.done          = done;
  assign sums.square_sum    = square_sum;
  assign sums.variation_sum = variation_sum;
  assign sums.overflow      = overflow;

endmodule

### design/eptv_scale.sv
`timescale 1ns / 1ps

module eptv_scale (
  input  logic                            clk,
  input  logic                            rst,
  input  eptv_pkg::sums_t                 sums,
  input  logic [eptv_pkg::INV_BITS-1:0]   inv,
  output logic                            busy,
  output logic                            result_valid,
  input  logic                            result_stall,
  output eptv_pkg::result_t               result
);

  localparam int AB = eptv_pkg::ACC_BITS;
  localparam int HB = eptv_pkg::HALF_BITS;
  localparam int PR = eptv_pkg::PROD_BITS;
  localparam int OB = eptv_pkg::OUT_BITS;
  localparam int FULL_BITS = PR + HB;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_HIGH  = 2'd2;
  localparam logic [1:0] ST_ROUND = 2'd3;

  logic [1:0]  state;
  logic [AB-1:0] total;
  logic          sat;
  logic [PR-1:0] prod_low;
  logic [PR-1:0] prod_high;

  logic [AB:0]          total_sum;
  logic [PR-1:0]        low_mult;
  logic [PR-1:0]        high_mult;
  logic [FULL_BITS-1:0] prod;
  logic [FULL_BITS-1:0] rounded;
  logic [OB:0]          loss_wide;
  logic                 out_free;

  always_comb begin
    total_sum = {2'b0, sums.square_sum[AB-1:1]} + {1'b0, sums.variation_sum};
    low_mult  = total[HB-1:0] * inv;
    high_mult = total[AB-1:HB] * inv;
    prod      = {prod_high, {HB{1'b0}}} + FULL_BITS'(prod_low);
    rounded   = prod + FULL_BITS'(32768);
    loss_wide = rounded[OB+16:16];
    out_free  = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= (state == ST_ROUND);
      end
      case (state)
        ST_IDLE: begin
          if (sums.done) begin
            state <= ST_LOW;
          end
        end
        ST_LOW:  state <= ST_HIGH;
        ST_HIGH: state <= ST_ROUND;
        ST_ROUND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sums.done) begin
      total <= total_sum[AB] ? eptv_pkg::ACC_MAX : total_sum[AB-1:0];
      sat   <= sums.overflow | total_sum[AB];
    end
    if (state == ST_LOW) begin
      prod_low <= low_mult;
    end
    if (state == ST_HIGH) begin
      prod_high <= high_mult;
    end
    if (state == ST_ROUND && out_free) begin
      result.loss      <= loss_wide[OB] ? eptv_pkg::OUT_MAX : loss_wide[OB-1:0];
      result.saturated <= sat | loss_wide[OB];
    end
  end

  assign busy = state != ST_IDLE;

endmodule
